// ----- hw/rtl/cid_pkg.sv -----
// Shared types and constants for the compressed integer decoder.
`default_nettype none
package cid_pkg;

  localparam int unsigned AccW    = 29;
  localparam int unsigned LenW    = 3;
  localparam int unsigned TokenW  = 32;
  localparam int unsigned RowW    = 24;
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 72;

  localparam logic [7:0] TableTypeDef  = 8'h02;
  localparam logic [7:0] TableTypeRef  = 8'h01;
  localparam logic [7:0] TableTypeSpec = 8'h1B;

  localparam logic [7:0] LeadTwoByteXor  = 8'h80;
  localparam logic [7:0] LeadFourByteXor = 8'hC0;

  localparam logic [LenW-1:0] LenOne  = 3'd1;
  localparam logic [LenW-1:0] LenTwo  = 3'd2;
  localparam logic [LenW-1:0] LenFour = 3'd4;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_ILL_FORMED   = 3'd1,
    ST_TRUNCATED    = 3'd2,
    ST_BAD_TAG      = 3'd3,
    ST_ROW_TOO_LARGE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MODE_UNSIGNED = 2'd0,
    MODE_SIGNED   = 2'd1,
    MODE_TOKEN    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    TAG_TYPEDEF  = 2'd0,
    TAG_TYPEREF  = 2'd1,
    TAG_TYPESPEC = 2'd2
  } tag_e;

  // One finished value or error, handed from the assembler to the formatter.
  typedef struct packed {
    logic            valid;
    status_e         status;
    logic [AccW-1:0] acc;
    logic [LenW-1:0] len;
    mode_e           mode;
  } cid_event_t;

  typedef struct packed {
    status_e                status;
    logic [TokenW-1:0]      unsigned_or_token;
    logic signed [AccW-1:0] signed_value;
    logic [LenW-1:0]        encoded_length;
  } cid_result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/compressed_integer_decoder_top.sv -----
// A result enters the output register on the transfer of its last byte.
// Throughput: one byte per cycle unless stalled; assembler registers advance per transfer.
// The input stalls only while a result waits in the output register and is not taken.
// Reset clears the assembler to idle between values and empties the output register.
// An end marker with no value in progress is consumed without a result.
`default_nettype none
module compressed_integer_decoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // action[1:0], data_byte[9:2], zero fill
  input  wire logic        s_axis_tlast,  // end_of_range
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[2:0], unsigned_or_token[34:3], signed_value[63:35], encoded_length[66:64],
  // zero fill
  output logic [71:0]      m_axis_tdata
);
  import cid_pkg::*;

  logic        accept;
  logic        load_en;
  cid_event_t  evt;
  cid_result_t res;
  logic        out_valid_q, out_valid_d;
  cid_result_t out_q;

  assign load_en       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = load_en;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cid_assembler u_assembler (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .action_i       (s_axis_tdata[1:0]),
    .data_byte_i    (s_axis_tdata[9:2]),
    .end_of_range_i (s_axis_tlast),
    .event_o        (evt)
  );

  cid_format u_format (
    .event_i  (evt),
    .result_o (res)
  );

  assign out_valid_d = load_en ? evt.valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en && evt.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.encoded_length, out_q.signed_value,
                          out_q.unsigned_or_token, out_q.status};

endmodule
`default_nettype wire

// ----- hw/rtl/cid_assembler.sv -----
// Byte assembler: tracks the length of the current value and gathers its payload bits.
`default_nettype none
module cid_assembler (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [1:0]         action_i,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic               end_of_range_i,
  output cid_pkg::cid_event_t     event_o
);
  import cid_pkg::*;

  mode_e           mode_q, mode_d;
  logic [1:0]      remain_q, remain_d;
  logic [LenW-1:0] len_q, len_d;
  logic [AccW-1:0] acc_q, acc_d;
  mode_e           sel_mode;
  logic [AccW-1:0] acc_shift;

  // A selector of three decodes as unsigned.
  always_comb begin
    case (action_i)
      MODE_SIGNED: sel_mode = MODE_SIGNED;
      MODE_TOKEN:  sel_mode = MODE_TOKEN;
      default:     sel_mode = MODE_UNSIGNED;
    endcase
  end

  assign acc_shift = {acc_q[AccW-9:0], data_byte_i};

  always_comb begin
    mode_d   = mode_q;
    remain_d = remain_q;
    len_d    = len_q;
    acc_d    = acc_q;
    event_o  = '0;
    event_o.status = ST_OK;
    event_o.mode   = MODE_UNSIGNED;

    if (accept_i) begin
      if (remain_q == 2'd0) begin
        if (!end_of_range_i) begin
          mode_d = sel_mode;
          if (!data_byte_i[7]) begin
            event_o.valid = 1'b1;
            event_o.acc   = AccW'(data_byte_i);
            event_o.len   = LenOne;
            event_o.mode  = sel_mode;
            len_d = '0;
            acc_d = '0;
          end else if (!data_byte_i[6]) begin
            len_d    = LenTwo;
            remain_d = 2'd1;
            acc_d    = AccW'(data_byte_i ^ LeadTwoByteXor);
          end else if (!data_byte_i[5]) begin
            len_d    = LenFour;
            remain_d = 2'd3;
            acc_d    = AccW'(data_byte_i ^ LeadFourByteXor);
          end else begin
            event_o.valid  = 1'b1;
            event_o.status = ST_ILL_FORMED;
            len_d = '0;
            acc_d = '0;
          end
        end
      end else if (end_of_range_i) begin
        event_o.valid  = 1'b1;
        event_o.status = ST_TRUNCATED;
        remain_d = 2'd0;
        len_d    = '0;
        acc_d    = '0;
      end else begin
        remain_d = remain_q - 2'd1;
        if (remain_q == 2'd1) begin
          event_o.valid = 1'b1;
          event_o.acc   = acc_shift;
          event_o.len   = len_q;
          event_o.mode  = mode_q;
          len_d = '0;
          acc_d = '0;
        end else begin
          acc_d = acc_shift;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_UNSIGNED;
      remain_q <= 2'd0;
      len_q    <= '0;
      acc_q    <= '0;
    end else begin
      mode_q   <= mode_d;
      remain_q <= remain_d;
      len_q    <= len_d;
      acc_q    <= acc_d;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/cid_format.sv -----
// Result formatter: turns a finished payload into an unsigned, signed or token result, or an error.
`default_nettype none
module cid_format (
  input  wire cid_pkg::cid_event_t  event_i,
  output cid_pkg::cid_result_t      result_o
);
  import cid_pkg::*;

  logic [AccW-1:0] sval;
  logic [AccW-1:0] sign_mask;
  logic [7:0]      table_id;
  logic            tag_ok;

  // Signed mode: the low bit is the sign, extended above the payload width.
  always_comb begin
    case (event_i.len)
      LenOne:  sign_mask = {{(AccW-6){1'b1}}, 6'd0};
      LenTwo:  sign_mask = {{(AccW-13){1'b1}}, 13'd0};
      default: sign_mask = {1'b1, {(AccW-1){1'b0}}};
    endcase
    sval = {1'b0, event_i.acc[AccW-1:1]};
    if (event_i.acc[0]) begin
      sval = sval | sign_mask;
    end
  end

  always_comb begin
    tag_ok = 1'b1;
    case (tag_e'(event_i.acc[1:0]))
      TAG_TYPEDEF:  table_id = TableTypeDef;
      TAG_TYPEREF:  table_id = TableTypeRef;
      TAG_TYPESPEC: table_id = TableTypeSpec;
      default: begin
        table_id = '0;
        tag_ok   = 1'b0;
      end
    endcase
  end

  always_comb begin
    result_o = '0;
    result_o.status = ST_OK;
    if (event_i.status != ST_OK) begin
      result_o.status = event_i.status;
    end else begin
      case (event_i.mode)
        MODE_SIGNED: begin
          result_o.signed_value   = sval;
          result_o.encoded_length = event_i.len;
        end
        MODE_TOKEN: begin
          if (!tag_ok) begin
            result_o.status = ST_BAD_TAG;
          end else if (event_i.acc[AccW-1:RowW+2] != '0) begin
            result_o.status = ST_ROW_TOO_LARGE;
          end else begin
            result_o.unsigned_or_token = {table_id, event_i.acc[RowW+1:2]};
            result_o.encoded_length    = event_i.len;
          end
        end
        default: begin
          result_o.unsigned_or_token = TokenW'(event_i.acc);
          result_o.encoded_length    = event_i.len;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
